// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Holds operation and status codes, controller states and the command and
// status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int Depth    = 64;
	localparam int KeyBits  = 16;
	localparam int TagBits  = 16;
	localparam int PosBits  = $clog2(Depth);
	localparam int CntBits  = $clog2(Depth + 1);

	typedef enum logic [2:0] {
		OP_OFFER  = 3'd0,
		OP_POLL   = 3'd1,
		OP_REM_AT = 3'd2,
		OP_REM_TAG = 3'd3,
		OP_READ_AT = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SEARCH,
		S_SHIFT_UP,
		S_SHIFT_DOWN,
		S_COMPACT,
		S_HEAD,
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // latch request and clear result
		logic search;     // offer search step at scan index
		logic up_start;   // note insert point, aim pointers at the top entry
		logic shift_up;   // move entry rd to wr = rd+1, step down
		logic place;      // write new entry at insert point
		logic read_out;   // capture read data as out entry
		logic shift_down; // move entry rd to wr = rd-1, step up
		logic compact;    // remove-tag step
		logic head;       // point the read port at the head entry
		logic capture;    // load the result register
		logic set_count;  // fill count from compaction index
		logic dec_count;
		logic inc_count;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic    scan_done;  // scan index reached fill count
		logic    found;      // stored key comes after the new key
		logic    up_done;    // shift pointer reached insert point
		logic    down_done;  // shift pointer reached fill count
		op_t     op;
		logic    empty;
		logic    full;
		logic    pos_bad;
	} stat_t;

endpackage

// ===== sv/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue: sorted-array priority queue of (key, tag) entries
// Offer, poll, remove at, remove tag and read at over a packed sorted store.
//
//  channel   dir  signals
//  request   in   s_axis_tvalid/tready/tdata
//  result    out  m_axis_tvalid/tready/tdata
//  config    in   cfg_we/cfg_wdata
//
// One request at a time; the store is walked through the single memory read
// port, one entry per cycle.
// Reset empties the queue at once; no clearing pass.
// A result waits in its register until taken; the next request runs meanwhile
// and holds in its last cycle until the register frees.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op[2:0], item_key[18:3], item_tag[34:19], position[40:35]
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[1:0], placed_at[7:2], out_key[23:8], out_tag[39:24],
	// removed_count[46:40], head_valid[47], head_key[63:48],
	// head_tag[79:64], entry_count[86:80]
	output logic [87:0] m_axis_tdata
);

	logic             desc_q;
	spq_pkg::cmd_t    cmd;
	spq_pkg::stat_t   stat;
	spq_pkg::status_t status;
	logic [5:0]  placed_at;
	logic [15:0] out_key, out_tag, head_key, head_tag;
	logic [6:0]  removed_count, entry_count;
	logic        head_valid;

	// hold order register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) desc_q <= 1'b0;
		else if (cfg_we) desc_q <= cfg_wdata;
	end

	spq_ctrl u_ctrl (
		.clk, .arst_n,
		.req_valid(s_axis_tvalid), .req_ready(s_axis_tready),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
		.stat, .cmd, .status
	);

	spq_dp u_dp (
		.clk, .arst_n,
		.descending_order(desc_q),
		.op(s_axis_tdata[2:0]),
		.item_key(s_axis_tdata[18:3]),
		.item_tag(s_axis_tdata[34:19]),
		.position(s_axis_tdata[40:35]),
		.cmd, .stat,
		.placed_at, .out_key, .out_tag, .removed_count,
		.head_valid, .head_key, .head_tag, .entry_count
	);

	assign m_axis_tdata = {1'b0, entry_count, head_tag, head_key, head_valid,
	                       removed_count, out_tag, out_key, placed_at, status};

endmodule

// ===== sv/spq_ctrl.sv =====
// ----------------------------------------------------------------------------
// spq_ctrl: sequencer for the sorted priority queue
// Steps each request through search, shift or compaction, and head capture phases.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              res_valid,
	input  logic              res_ready,
	input  spq_pkg::stat_t    stat,
	output spq_pkg::cmd_t     cmd,
	output spq_pkg::status_t  status
);

	spq_pkg::state_t state_q, state_d;
	spq_pkg::status_t status_q, status_d;
	spq_pkg::status_t res_status_q;
	logic             res_valid_q;

	// hold state, result status and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= spq_pkg::S_IDLE;
			status_q     <= spq_pkg::ST_OK;
			res_status_q <= spq_pkg::ST_OK;
			res_valid_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			if (cmd.capture) begin
				res_status_q <= status_q;
				res_valid_q  <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign status    = res_status_q;
	assign res_valid = res_valid_q;

	// next state and commands
	always_comb begin
		state_d   = state_q;
		status_d  = status_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					status_d = spq_pkg::ST_OK;
					state_d  = spq_pkg::S_DISPATCH;
				end
			end
			spq_pkg::S_DISPATCH: begin
				// dispatch on the latched op
				state_d = spq_pkg::S_HEAD;
				unique case (stat.op)
					spq_pkg::OP_OFFER: begin
						if (stat.full) status_d = spq_pkg::ST_FULL;
						else state_d = spq_pkg::S_SEARCH;
					end
					spq_pkg::OP_POLL, spq_pkg::OP_REM_AT, spq_pkg::OP_READ_AT: begin
						if (stat.empty) status_d = spq_pkg::ST_EMPTY;
						else if (stat.pos_bad) status_d = spq_pkg::ST_RANGE;
						else begin
							cmd.read_out = 1'b1;
							if (stat.op != spq_pkg::OP_READ_AT)
								state_d = spq_pkg::S_SHIFT_DOWN;
						end
					end
					spq_pkg::OP_REM_TAG: begin
						if (stat.empty) status_d = spq_pkg::ST_EMPTY;
						else state_d = spq_pkg::S_COMPACT;
					end
					// undefined op: leave the store alone
					default: state_d = spq_pkg::S_HEAD;
				endcase
			end
			spq_pkg::S_SEARCH: begin
				if (stat.scan_done || stat.found) begin
					cmd.up_start = 1'b1;
					state_d      = spq_pkg::S_SHIFT_UP;
				end else cmd.search = 1'b1;
			end
			spq_pkg::S_SHIFT_UP: begin
				if (stat.up_done) begin
					cmd.place     = 1'b1;
					cmd.inc_count = 1'b1;
					state_d       = spq_pkg::S_HEAD;
				end else cmd.shift_up = 1'b1;
			end
			spq_pkg::S_SHIFT_DOWN: begin
				if (stat.down_done) begin
					cmd.dec_count = 1'b1;
					state_d       = spq_pkg::S_HEAD;
				end else cmd.shift_down = 1'b1;
			end
			spq_pkg::S_COMPACT: begin
				if (stat.scan_done) begin
					cmd.set_count = 1'b1;
					state_d       = spq_pkg::S_HEAD;
				end else cmd.compact = 1'b1;
			end
			spq_pkg::S_HEAD: begin
				// read the head entry once the store has settled
				cmd.head = 1'b1;
				state_d  = spq_pkg::S_DONE;
			end
			spq_pkg::S_DONE: begin
				// hand the result over once the result register is free
				if (!res_valid_q || res_ready) begin
					cmd.capture = 1'b1;
					state_d     = spq_pkg::S_IDLE;
				end
			end
			default: state_d = spq_pkg::S_IDLE;
		endcase
	end

endmodule

// ===== sv/spq_dp.sv =====
// ----------------------------------------------------------------------------
// spq_dp: storage and data path of the sorted priority queue
// Key and tag memories with one read and one write port, scan pointers,
// fill count and result registers.
// ----------------------------------------------------------------------------
module spq_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              descending_order,
	input  logic [2:0]                        op,
	input  logic [spq_pkg::KeyBits-1:0]       item_key,
	input  logic [spq_pkg::TagBits-1:0]       item_tag,
	input  logic [spq_pkg::PosBits-1:0]       position,
	input  spq_pkg::cmd_t                     cmd,
	output spq_pkg::stat_t                    stat,
	output logic [spq_pkg::PosBits-1:0]       placed_at,
	output logic [spq_pkg::KeyBits-1:0]       out_key,
	output logic [spq_pkg::TagBits-1:0]       out_tag,
	output logic [spq_pkg::CntBits-1:0]       removed_count,
	output logic                              head_valid,
	output logic [spq_pkg::KeyBits-1:0]       head_key,
	output logic [spq_pkg::TagBits-1:0]       head_tag,
	output logic [spq_pkg::CntBits-1:0]       entry_count
);

	localparam int PB = spq_pkg::PosBits;
	localparam int CB = spq_pkg::CntBits;

	logic [spq_pkg::KeyBits-1:0] key_mem [spq_pkg::Depth];
	logic [spq_pkg::TagBits-1:0] tag_mem [spq_pkg::Depth];

	spq_pkg::op_t                op_q;
	logic [spq_pkg::KeyBits-1:0] key_q;
	logic [spq_pkg::TagBits-1:0] tag_q;
	logic [PB-1:0]               pos_q;
	logic [CB-1:0]               fill_q;
	logic [CB-1:0]               rd_q;   // read pointer, rkey_q/rtag_q hold its entry
	logic [CB-1:0]               wr_q;   // write pointer
	logic [CB-1:0]               ins_q;  // insert point of an offer
	logic [spq_pkg::KeyBits-1:0] rkey_q;
	logic [spq_pkg::TagBits-1:0] rtag_q;
	logic [CB-1:0]               rd_d;
	logic [PB-1:0]               plc_q;
	logic [spq_pkg::KeyBits-1:0] okey_q;
	logic [spq_pkg::TagBits-1:0] otag_q;
	logic [CB-1:0]               rcnt_q;

	logic [CB-1:0] eff_pos;
	logic          after;

	assign eff_pos = (op_q == spq_pkg::OP_POLL) ? '0 : CB'(pos_q);
	assign after   = descending_order ? (rkey_q < key_q) : (rkey_q > key_q);

	// read address for the next cycle
	always_comb begin
		priority if (cmd.load) begin
			rd_d = (op == 3'(spq_pkg::OP_REM_AT) || op == 3'(spq_pkg::OP_READ_AT))
			       ? CB'(position) : '0;
		end else if (cmd.search || cmd.compact || cmd.shift_down || cmd.read_out)
			rd_d = rd_q + 1'b1;
		else if (cmd.up_start) rd_d = fill_q - 1'b1;
		else if (cmd.shift_up) rd_d = rd_q - 1'b1;
		else if (cmd.head) rd_d = '0;
		else rd_d = rd_q;
	end

	// registered memory read
	always_ff @(posedge clk) begin
		rkey_q <= key_mem[rd_d[PB-1:0]];
		rtag_q <= tag_mem[rd_d[PB-1:0]];
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (cmd.place) begin
			key_mem[wr_q[PB-1:0]] <= key_q;
			tag_mem[wr_q[PB-1:0]] <= tag_q;
		end else if (cmd.shift_up || cmd.shift_down || (cmd.compact && rtag_q != tag_q)) begin
			key_mem[wr_q[PB-1:0]] <= rkey_q;
			tag_mem[wr_q[PB-1:0]] <= rtag_q;
		end
	end

	// request latch, pointers and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q        <= '0;
			op_q          <= spq_pkg::OP_OFFER;
			rd_q          <= '0;
			wr_q          <= '0;
			ins_q         <= '0;
			plc_q         <= '0;
			okey_q        <= '0;
			otag_q        <= '0;
			rcnt_q        <= '0;
			placed_at     <= '0;
			out_key       <= '0;
			out_tag       <= '0;
			removed_count <= '0;
			head_valid    <= 1'b0;
			head_key      <= '0;
			head_tag      <= '0;
			entry_count   <= '0;
			key_q         <= '0;
			tag_q         <= '0;
			pos_q         <= '0;
		end else begin
			rd_q <= rd_d;
			if (cmd.load) begin
				op_q   <= spq_pkg::op_t'(op);
				key_q  <= item_key;
				tag_q  <= item_tag;
				pos_q  <= position;
				plc_q  <= '0;
				okey_q <= '0;
				otag_q <= '0;
				rcnt_q <= '0;
				wr_q   <= '0;
			end
			// offer: search ends at the insert point, shift from the top down
			if (cmd.up_start) begin
				ins_q <= rd_q;
				wr_q  <= fill_q;
			end
			if (cmd.shift_up) wr_q <= wr_q - 1'b1;
			if (cmd.place) plc_q <= ins_q[PB-1:0];
			if (cmd.read_out) begin
				okey_q <= rkey_q;
				otag_q <= rtag_q;
				wr_q   <= eff_pos;
			end
			if (cmd.shift_down) wr_q <= wr_q + 1'b1;
			if (cmd.compact) begin
				if (rtag_q != tag_q) wr_q <= wr_q + 1'b1;
				else rcnt_q <= rcnt_q + 1'b1;
			end
			if (cmd.set_count) fill_q <= wr_q;
			if (cmd.inc_count) fill_q <= fill_q + 1'b1;
			if (cmd.dec_count) fill_q <= fill_q - 1'b1;
			// load the result register; the read port holds the head entry
			if (cmd.capture) begin
				placed_at     <= plc_q;
				out_key       <= okey_q;
				out_tag       <= otag_q;
				removed_count <= rcnt_q;
				head_valid    <= (fill_q != '0);
				head_key      <= (fill_q != '0) ? rkey_q : '0;
				head_tag      <= (fill_q != '0) ? rtag_q : '0;
				entry_count   <= fill_q;
			end
		end
	end

	always_comb begin
		stat.op        = op_q;
		stat.empty     = (fill_q == '0);
		stat.full      = (fill_q == CB'(spq_pkg::Depth));
		stat.pos_bad   = (eff_pos >= fill_q);
		stat.scan_done = (rd_q == fill_q);
		stat.found     = (rd_q != fill_q) && after;
		stat.up_done   = (wr_q == ins_q);
		stat.down_done = (rd_q == fill_q);
	end

endmodule
